>>> rtl/iso_ts_pkg.sv
// ----------------------------------------------------------------------------
// iso_ts_pkg
// Types, codes and constants shared by the timestamp parser, queue and converter.
// ----------------------------------------------------------------------------
package iso_ts_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_FIXED      = 3'd0,
    PH_AFTER_SEC  = 3'd1,
    PH_FRAC_FIRST = 3'd2,
    PH_FRAC_MORE  = 3'd3,
    PH_OFFSET     = 3'd4,
    PH_DONE       = 3'd5
  } phase_t;

  // converter sequence
  typedef enum logic [2:0] {
    CV_IDLE = 3'd0,
    CV_PREP = 3'd1,
    CV_DAYS = 3'd2,
    CV_SECS = 3'd3,
    CV_OUT  = 3'd4
  } conv_state_t;

  // character codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_T_UP   = 8'h54;
  localparam logic [7:0] CH_T_LOW  = 8'h74;
  localparam logic [7:0] CH_Z_UP   = 8'h5A;
  localparam logic [7:0] CH_Z_LOW  = 8'h7A;

  // arithmetic constants
  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;
  localparam int unsigned MIN_SECONDS  = 60;
  localparam int unsigned YEAR_DAYS    = 365;
  // years are biased by one 400-year era so the day count never sees a negative year
  localparam int unsigned YEAR_BIAS    = 400;
  localparam int unsigned EPOCH_SHIFT  = 719468 + 146097;
  // x / 25 == (x * 5243) >> 17 for x below 43000
  localparam int unsigned DIV25_MUL    = 5243;
  localparam int unsigned DIV25_SHIFT  = 17;

  localparam int unsigned SECS_W = 39;

  // one parsed timestamp, handed from parser to converter
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  zone_hours;
    logic [6:0]  zone_minutes;
    logic        zone_negative;
  } stamp_rec_t;

  // days from March 1 to the first of the month (year starting in March)
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] r;
    case (month)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/iso_ts_if.sv
// ----------------------------------------------------------------------------
// iso_ts_if
// Valid/ready stream channels for timestamp text and conversion results.
// ----------------------------------------------------------------------------
interface iso_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface iso_stamp_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic signed [38:0] unix_seconds;

  modport source (output valid, output valid_res, output unix_seconds, input ready);
  modport sink   (input valid, input valid_res, input unix_seconds, output ready);
endinterface

>>> rtl/iso_ts_parse.sv
// ----------------------------------------------------------------------------
// iso_ts_parse
// Front end: takes one text byte per transfer, tracks the timestamp grammar and
// pushes a parsed record on the final byte.
// ----------------------------------------------------------------------------
module iso_ts_parse (
  input  logic                    clk,
  input  logic                    rst,
  iso_text_if.sink                text,
  input  logic                    full,
  output logic                    push,
  output iso_ts_pkg::stamp_rec_t  push_rec
);

  iso_ts_pkg::phase_t phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next, day, day_next, hour, hour_next;
  logic [6:0]  minute, minute_next, second, second_next;
  logic [6:0]  zone_hours, zone_hours_next, zone_minutes, zone_minutes_next;
  logic        zone_negative, zone_negative_next;
  logic        err, err_next;
  logic        accept, is_dig, ok;
  logic [7:0]  c;
  logic [3:0]  dig;

  function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
    return (a << 3) + (a << 1) + {3'b000, d};
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
    return (a << 3) + (a << 1) + {10'd0, d};
  endfunction

  assign c      = text.char_code;
  assign dig    = c[3:0];
  assign is_dig = (c >= iso_ts_pkg::CH_ZERO) && (c <= iso_ts_pkg::CH_NINE);
  assign accept = text.valid && text.ready;

  // next parser state for the current byte
  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    year_next          = year;
    month_next         = month;
    day_next           = day;
    hour_next          = hour;
    minute_next        = minute;
    second_next        = second;
    zone_hours_next    = zone_hours;
    zone_minutes_next  = zone_minutes;
    zone_negative_next = zone_negative;
    err_next           = err;
    ok                 = 1'b1;
    if (!err) begin
      case (phase)
        iso_ts_pkg::PH_FIXED: begin
          if (pos <= 5'd3) begin
            ok = is_dig;
            year_next = acc14(year, dig);
          end else if (pos == 5'd4 || pos == 5'd7) begin
            ok = (c == iso_ts_pkg::CH_DASH);
          end else if (pos == 5'd5 || pos == 5'd6) begin
            ok = is_dig;
            month_next = acc7(month, dig);
          end else if (pos == 5'd8 || pos == 5'd9) begin
            ok = is_dig;
            day_next = acc7(day, dig);
          end else if (pos == 5'd10) begin
            ok = (c == iso_ts_pkg::CH_T_UP) || (c == iso_ts_pkg::CH_T_LOW);
          end else if (pos == 5'd11 || pos == 5'd12) begin
            ok = is_dig;
            hour_next = acc7(hour, dig);
          end else if (pos == 5'd13 || pos == 5'd16) begin
            ok = (c == iso_ts_pkg::CH_COLON);
          end else if (pos == 5'd14 || pos == 5'd15) begin
            ok = is_dig;
            minute_next = acc7(minute, dig);
          end else begin
            ok = is_dig;
            second_next = acc7(second, dig);
          end
          if (!ok) begin
            err_next    = 1'b1;
            year_next   = year;
            month_next  = month;
            day_next    = day;
            hour_next   = hour;
            minute_next = minute;
            second_next = second;
          end else if (pos >= 5'd18) begin
            phase_next = iso_ts_pkg::PH_AFTER_SEC;
            pos_next   = '0;
          end else begin
            pos_next = pos + 5'd1;
          end
        end
        iso_ts_pkg::PH_AFTER_SEC, iso_ts_pkg::PH_FRAC_MORE: begin
          if (phase == iso_ts_pkg::PH_AFTER_SEC && c == iso_ts_pkg::CH_DOT) begin
            phase_next = iso_ts_pkg::PH_FRAC_FIRST;
          end else if (phase == iso_ts_pkg::PH_FRAC_MORE && is_dig) begin
            phase_next = phase;
          end else if (c == iso_ts_pkg::CH_Z_UP || c == iso_ts_pkg::CH_Z_LOW) begin
            phase_next = iso_ts_pkg::PH_DONE;
          end else if (c == iso_ts_pkg::CH_PLUS || c == iso_ts_pkg::CH_DASH) begin
            zone_negative_next = (c == iso_ts_pkg::CH_DASH);
            pos_next           = '0;
            phase_next         = iso_ts_pkg::PH_OFFSET;
          end else begin
            err_next = 1'b1;
          end
        end
        iso_ts_pkg::PH_FRAC_FIRST: begin
          if (is_dig) begin
            phase_next = iso_ts_pkg::PH_FRAC_MORE;
          end else begin
            err_next = 1'b1;
          end
        end
        iso_ts_pkg::PH_OFFSET: begin
          if (pos <= 5'd1) begin
            ok = is_dig;
            zone_hours_next = ok ? acc7(zone_hours, dig) : zone_hours;
          end else if (pos == 5'd2) begin
            ok = (c == iso_ts_pkg::CH_COLON);
          end else begin
            ok = is_dig;
            zone_minutes_next = ok ? acc7(zone_minutes, dig) : zone_minutes;
          end
          if (!ok) begin
            err_next = 1'b1;
          end else if (pos >= 5'd4) begin
            phase_next = iso_ts_pkg::PH_DONE;
          end else begin
            pos_next = pos + 5'd1;
          end
        end
        default: begin
          // any byte after a complete zone
          err_next = 1'b1;
        end
      endcase
    end
  end

  // outputs to the queue
  always_comb begin
    text.ready             = !full;
    push                   = accept && text.end_of_text;
    push_rec.ok            = !err_next && (phase_next == iso_ts_pkg::PH_DONE)
                             && (month_next >= 7'd1) && (month_next <= 7'd12)
                             && (day_next >= 7'd1) && (day_next <= 7'd31)
                             && (hour_next <= 7'd23) && (minute_next <= 7'd59)
                             && (second_next <= 7'd60);
    push_rec.year          = year_next;
    push_rec.month         = month_next;
    push_rec.day           = day_next;
    push_rec.hour          = hour_next;
    push_rec.minute        = minute_next;
    push_rec.second        = second_next;
    push_rec.zone_hours    = zone_hours_next;
    push_rec.zone_minutes  = zone_minutes_next;
    push_rec.zone_negative = zone_negative_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase         <= iso_ts_pkg::PH_FIXED;
      pos           <= '0;
      year          <= '0;
      month         <= '0;
      day           <= '0;
      hour          <= '0;
      minute        <= '0;
      second        <= '0;
      zone_hours    <= '0;
      zone_minutes  <= '0;
      zone_negative <= 1'b0;
      err           <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      pos           <= pos_next;
      year          <= year_next;
      month         <= month_next;
      day           <= day_next;
      hour          <= hour_next;
      minute        <= minute_next;
      second        <= second_next;
      zone_hours    <= zone_hours_next;
      zone_minutes  <= zone_minutes_next;
      zone_negative <= zone_negative_next;
      err           <= err_next;
    end
  end

endmodule

>>> rtl/iso_ts_queue.sv
// ----------------------------------------------------------------------------
// iso_ts_queue
// Small first-in first-out queue of parsed records between parser and converter.
// ----------------------------------------------------------------------------
module iso_ts_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  iso_ts_pkg::stamp_rec_t  push_rec,
  output logic                    full,
  input  logic                    pop,
  output logic                    avail,
  output iso_ts_pkg::stamp_rec_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  iso_ts_pkg::stamp_rec_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/iso_ts_conv.sv
// ----------------------------------------------------------------------------
// iso_ts_conv
// Back end: turns one parsed record into Unix seconds over three arithmetic
// steps and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module iso_ts_conv (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    avail,
  input  iso_ts_pkg::stamp_rec_t  head,
  output logic                    pop,
  iso_stamp_if.source             stamp
);

  iso_ts_pkg::conv_state_t state, state_next;
  iso_ts_pkg::stamp_rec_t  rec;

  logic [14:0]        yb;        // biased march-based year
  logic [23:0]        y365;
  logic [25:0]        p100, p400;
  logic [19:0]        tod, off;
  logic signed [24:0] days;
  logic signed [20:0] tod_adj;
  logic               res_ok;
  logic signed [38:0] secs;

  logic [14:0]        yb_calc;
  logic signed [25:0] days_sum;
  logic signed [42:0] secs_sum;

  assign yb_calc = {1'b0, rec.year} + 15'(iso_ts_pkg::YEAR_BIAS)
                   - ((rec.month <= 7'd2) ? 15'd1 : 15'd0);

  assign days_sum = $signed({2'b00, y365})
                  + $signed({13'd0, yb[14:2]})
                  - $signed({17'd0, p100[25:iso_ts_pkg::DIV25_SHIFT]})
                  + $signed({17'd0, p400[25:iso_ts_pkg::DIV25_SHIFT]})
                  + $signed({17'd0, iso_ts_pkg::month_start(rec.month[3:0])})
                  + $signed({19'd0, rec.day})
                  - 26'sd1
                  - $signed(26'(iso_ts_pkg::EPOCH_SHIFT));

  assign secs_sum = days * $signed(18'(iso_ts_pkg::DAY_SECONDS)) + 43'(tod_adj);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      iso_ts_pkg::CV_IDLE: if (avail) state_next = iso_ts_pkg::CV_PREP;
      iso_ts_pkg::CV_PREP: state_next = iso_ts_pkg::CV_DAYS;
      iso_ts_pkg::CV_DAYS: state_next = iso_ts_pkg::CV_SECS;
      iso_ts_pkg::CV_SECS: state_next = iso_ts_pkg::CV_OUT;
      iso_ts_pkg::CV_OUT:  if (stamp.ready) state_next = iso_ts_pkg::CV_IDLE;
      default:             state_next = iso_ts_pkg::CV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop                = (state == iso_ts_pkg::CV_IDLE) && avail;
    stamp.valid        = (state == iso_ts_pkg::CV_OUT);
    stamp.valid_res    = res_ok;
    stamp.unix_seconds = secs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iso_ts_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      iso_ts_pkg::CV_IDLE: begin
        if (avail) rec <= head;
      end
      iso_ts_pkg::CV_PREP: begin
        yb   <= yb_calc;
        y365 <= 24'(yb_calc * 9'(iso_ts_pkg::YEAR_DAYS));
        p100 <= 26'(yb_calc[14:2] * 13'(iso_ts_pkg::DIV25_MUL));
        p400 <= 26'({2'b00, yb_calc[14:4]} * 13'(iso_ts_pkg::DIV25_MUL));
        tod  <= 20'(rec.hour * 12'(iso_ts_pkg::HOUR_SECONDS))
              + 20'(rec.minute * 6'(iso_ts_pkg::MIN_SECONDS))
              + {13'd0, rec.second};
        off  <= 20'(rec.zone_hours * 12'(iso_ts_pkg::HOUR_SECONDS))
              + 20'(rec.zone_minutes * 6'(iso_ts_pkg::MIN_SECONDS));
      end
      iso_ts_pkg::CV_DAYS: begin
        days    <= days_sum[24:0];
        tod_adj <= rec.zone_negative ? $signed({1'b0, tod}) + $signed({1'b0, off})
                                     : $signed({1'b0, tod}) - $signed({1'b0, off});
      end
      iso_ts_pkg::CV_SECS: begin
        res_ok <= rec.ok;
        secs   <= rec.ok ? secs_sum[38:0] : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/iso_timestamp_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch_seconds
// Streams timestamp text of the form yyyy-MM-ddTHH:mm:ss[.f+](Z|+HH:mm|-HH:mm)
// and returns one validity flag and Unix seconds per string.
// ----------------------------------------------------------------------------
// The text channel takes one byte per cycle with no gaps of its own: the parser
// checks the grammar and range limits as the bytes go by and, on the byte marked
// end_of_text, drops one parsed record into a QUEUE_DEPTH-entry queue. The
// converter takes each record from that queue through load, year and
// time-of-day products, day count, day-to-second product and result register
// before it pops the next, so that loop limits throughput; strings whose bytes
// outlast it stream at full byte rate while results are taken, and runs of
// shorter strings are absorbed by the queue until it fills, at which point text
// ready drops. With an empty queue, the final byte's record passes the queue
// slot, the load and the prep, day-count and seconds steps before result valid
// rises. A result that is not taken holds in the output register while the
// parser keeps accepting bytes. Invalid strings give valid_res low and zero
// seconds; the offset is applied as local time minus offset.
module iso_timestamp_to_epoch_seconds #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  iso_text_if.sink    text,
  iso_stamp_if.source stamp
);

  // parser to queue
  logic                   push;
  iso_ts_pkg::stamp_rec_t push_rec;
  logic                   full;

  // queue to converter
  logic                   pop;
  logic                   avail;
  iso_ts_pkg::stamp_rec_t head;

  // front end: grammar, digit accumulation and range checks
  iso_ts_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .full     (full),
    .push     (push),
    .push_rec (push_rec)
  );

  // decoupling queue so a stalled result does not stop the text stream
  iso_ts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  // back end: civil-days conversion and result register
  iso_ts_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .head  (head),
    .pop   (pop),
    .stamp (stamp)
  );

endmodule

>>> rtl/iso_ts_checker.sv
// ----------------------------------------------------------------------------
// iso_ts_checker
// Port-level checks on the timestamp converter, bound to the top level.
// ----------------------------------------------------------------------------
module iso_ts_checker (
  input logic        clk,
  input logic        rst,
  input logic        text_valid,
  input logic        text_ready,
  input logic        stamp_valid,
  input logic        stamp_ready,
  input logic        valid_res,
  input logic [38:0] unix_seconds
);

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && !stamp_ready |=> stamp_valid && $stable(valid_res)
                                    && $stable(unix_seconds))
    else $error("result changed while stalled");

  // failed strings carry zero seconds
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && !valid_res |-> unix_seconds == '0)
    else $error("invalid result with nonzero seconds");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !stamp_valid)
    else $error("result valid right after reset");

  // a later look that still sees no result after reset
  a_no_early_result: assert property (@(posedge clk)
    rst |=> ##1 !stamp_valid)
    else $error("result appeared too soon after reset");

  logic text_seen;
  always_ff @(posedge clk) begin
    if (rst) begin
      text_seen <= 1'b0;
    end else if (text_valid && text_ready) begin
      text_seen <= 1'b1;
    end
  end

  // a result needs some text transfer before it
  a_result_needs_text: assert property (@(posedge clk) disable iff (rst)
    stamp_valid |-> text_seen)
    else $error("result without any text transfer");

endmodule

bind iso_timestamp_to_epoch_seconds iso_ts_checker u_iso_ts_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text.valid),
  .text_ready   (text.ready),
  .stamp_valid  (stamp.valid),
  .stamp_ready  (stamp.ready),
  .valid_res    (stamp.valid_res),
  .unix_seconds (stamp.unix_seconds)
);
